/* sv/dcws_pkg.sv */
package dcws_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;

	// Configuration values after reset.
	localparam logic [9:0]  MIN_DIST_RST = 10'd70;
	localparam logic [9:0]  SPAN_RST     = 10'd320;
	localparam logic [9:0]  MAX_VOL_RST  = 10'd1000;
	localparam logic [10:0] MIN_FREQ_RST = 11'd20;
	localparam logic [10:0] MAX_FREQ_RST = 11'd1200;
	localparam logic [7:0]  RATE_RST     = 8'd48;
	localparam logic [10:0] WAVE_LEN_RST = 11'd1000;

	// Oscillator state after reset.
	localparam logic [23:0] STEP_RST   = 24'd131072;
	localparam logic [9:0]  VOLUME_RST = 10'd500;

	localparam logic [23:0] STEP_MAX = 24'hFFFFFF;
	localparam int          DAC_MID  = 2048;
	localparam int          DAC_MAX  = 4095;
	localparam int          PHASE_FRAC_W = 16;

	// Shift-add multiplier and restoring divider widths.
	localparam int MUL_A_W = 27;
	localparam int MUL_B_W = 13;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 28;
	localparam int DIV_C_W = $clog2(DIV_N_W + 1);

	typedef enum logic [2:0] {
		CFG_MIN_DIST = 3'd0,
		CFG_SPAN     = 3'd1,
		CFG_MAX_VOL  = 3'd2,
		CFG_MIN_FREQ = 3'd3,
		CFG_MAX_FREQ = 3'd4,
		CFG_RATE     = 3'd5,
		CFG_WAVE_LEN = 3'd6
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_VOL   = 2'd1,
		MODE_PITCH = 2'd2,
		MODE_WRITE = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_D,
		ST_SQ_S,
		ST_VOL_MUL,
		ST_VOL_DIV,
		ST_P_MUL1,
		ST_P_MUL2,
		ST_P_LIM,
		ST_P_DEN,
		ST_P_DIV,
		ST_T_MOD,
		ST_T_RD,
		ST_T_MUL,
		ST_T_DIV,
		ST_DONE
	} state_t;

endpackage

/* sv/dcws_if.sv */
interface dcws_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        mode;
	logic [12:0]       range_mm;
	logic [7:0]        range_status;
	logic [9:0]        table_index;
	logic signed [11:0] table_value;

	modport source(output valid, mode, range_mm, range_status, table_index, table_value,
		input ready);
	modport sink(input valid, mode, range_mm, range_status, table_index, table_value,
		output ready);
endinterface

interface dcws_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] dac_value;
	logic [9:0]  volume_level;
	logic [23:0] phase_step;
	logic [9:0]  table_position;

	modport source(output valid, dac_value, volume_level, phase_step, table_position,
		input ready);
	modport sink(input valid, dac_value, volume_level, phase_step, table_position,
		output ready);
endinterface

/* sv/distance_controlled_wavetable_synth.sv */
// Distance-controlled wavetable voice.
// Items arrive on the item channel and are taken when valid and ready are both high.
// Mode selects a sample tick, a volume measurement, a pitch measurement or a write
// of one waveform table entry. Each item yields exactly one transfer on the result
// channel carrying the DAC sample, volume, phase step and table position after it.
// One item is in work at a time. A table write or a bad measurement goes straight
// to the result; a tick runs a modulo division, a table read, a product and a
// division; a volume measurement two squares, a product and a division; a pitch
// measurement two squares, four products and a division, all on the shared
// shift-add multiplier and the shared restoring divider (one quotient bit per cycle,
// up to 47 bits for the phase step).
// A finished result sits in an output register, so the next item is taken while
// it waits; if the receiver stalls with that register full, the following
// result holds the sequencer until the pending transfer completes.
// Reset loads the default configuration, clears the phase, sets the step to
// 131072 and the volume to 500. The waveform table is not cleared and must be
// written before the entries a tick reaches are used. Configuration is written via
// cfg_we/cfg_index/cfg_data only while idle; the user, not the block, ensures it.
module distance_controlled_wavetable_synth #(
	parameter int TABLE_DEPTH = dcws_pkg::TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dcws_item_if.sink            item,
	dcws_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [10:0]          cfg_data
);
	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int LEN_W   = IDX_W + 1;
	localparam int PHASE_W = IDX_W + dcws_pkg::PHASE_FRAC_W;

	// Configuration registers.
	logic [9:0]  min_dist_q, span_q, max_vol_q;
	logic [10:0] pitch_lo_q, pitch_hi_q, wave_len_q;
	logic [7:0]  rate_q;

	// Oscillator state.
	logic [PHASE_W-1:0] phase_q;
	logic [23:0]        step_q;
	logic [9:0]         vol_q;
	logic [11:0]        sample_q;

	// Waveform table with a registered read port.
	logic signed [11:0] wave_mem [TABLE_DEPTH];
	logic signed [11:0] rd_q;

	// Captured item and intermediate results.
	dcws_pkg::mode_t    mode_q;
	logic [12:0]        range_q;
	logic [25:0]        d2_q;
	logic [19:0]        s2_q;
	logic [30:0]        t1_q;
	logic signed [38:0] num_q;
	logic [30:0]        nclamp_q;
	logic [27:0]        den_q;
	logic [39:0]        p_q;
	logic               neg_q;
	logic [28:0]        sum_q;
	logic               launch_q;

	// Result register.
	logic        res_valid_q;
	logic [11:0] o_dac_q;
	logic [9:0]  o_vol_q;
	logic [23:0] o_step_q;
	logic [9:0]  o_pos_q;

	dcws_pkg::state_t state_q, state_d;

	logic                         item_xfer;
	logic                         res_free;
	logic                         mul_start, mul_done;
	logic [dcws_pkg::MUL_A_W-1:0] mul_a;
	logic [dcws_pkg::MUL_B_W-1:0] mul_b;
	logic [dcws_pkg::MUL_P_W-1:0] mul_p;
	logic                         div_start, div_done;
	logic [dcws_pkg::DIV_N_W-1:0] div_num;
	logic [dcws_pkg::DIV_D_W-1:0] div_den;
	logic [dcws_pkg::DIV_C_W-1:0] div_n;
	logic [dcws_pkg::DIV_N_W-1:0] div_q;
	logic [dcws_pkg::DIV_D_W-1:0] div_r;

	logic [9:0]          span_eff, max_vol_eff;
	logic [7:0]          rate_eff;
	logic [LEN_W-1:0]    len_eff;
	logic signed [13:0]  d_s;
	logic [12:0]         d_mag;
	logic signed [11:0]  fdiff;
	logic [10:0]         fdiff_mag;
	logic [11:0]         rd_mag;
	logic signed [23:0]  samp_v;
	logic [31:0]         phase_ext;
	logic                bad_status;

	assign item_xfer  = item.valid && item.ready;
	assign res_free   = !res_valid_q || result.ready;
	assign bad_status = item.range_status != 8'd0;

	// Zero divisors are taken as one; the wave length is clamped to the table.
	assign span_eff    = (span_q == 10'd0) ? 10'd1 : span_q;
	assign max_vol_eff = (max_vol_q == 10'd0) ? 10'd1 : max_vol_q;
	assign rate_eff    = (rate_q == 8'd0) ? 8'd1 : rate_q;
	always_comb begin
		if (wave_len_q == 11'd0) begin
			len_eff = LEN_W'(1);
		end else if (32'(wave_len_q) > TABLE_DEPTH) begin
			len_eff = LEN_W'(TABLE_DEPTH);
		end else begin
			len_eff = LEN_W'(wave_len_q);
		end
	end

	// Excess distance is signed; only its magnitude enters the square.
	assign d_s       = $signed({1'b0, range_q}) - $signed({4'b0, min_dist_q});
	assign d_mag     = d_s[13] ? 13'(-d_s) : d_s[12:0];
	assign fdiff     = $signed({1'b0, pitch_hi_q}) - $signed({1'b0, pitch_lo_q});
	assign fdiff_mag = fdiff[11] ? 11'(-fdiff) : fdiff[10:0];
	assign rd_mag    = rd_q[11] ? 12'(-rd_q) : rd_q;
	assign phase_ext = 32'(phase_q);

	// Tick sample: midscale plus the signed quotient, saturated to the DAC range.
	assign samp_v = neg_q ? (24'sd2048 - $signed({2'b0, div_q[21:0]}))
	                      : (24'sd2048 + $signed({2'b0, div_q[21:0]}));

	dcws_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	dcws_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.n         (div_n),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// Operand selection for the shared arithmetic units.
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		div_num = '0;
		div_den = dcws_pkg::DIV_D_W'(1);
		div_n   = dcws_pkg::DIV_C_W'(1);
		case (state_q)
			dcws_pkg::ST_SQ_D: begin
				mul_a = dcws_pkg::MUL_A_W'(d_mag);
				mul_b = d_mag;
			end
			dcws_pkg::ST_SQ_S: begin
				mul_a = dcws_pkg::MUL_A_W'(span_eff);
				mul_b = dcws_pkg::MUL_B_W'(span_eff);
			end
			dcws_pkg::ST_VOL_MUL: begin
				mul_a = dcws_pkg::MUL_A_W'(d2_q);
				mul_b = dcws_pkg::MUL_B_W'(max_vol_q);
			end
			dcws_pkg::ST_VOL_DIV: begin
				div_num = {p_q[35:0], 12'd0};
				div_den = dcws_pkg::DIV_D_W'(s2_q);
				div_n   = dcws_pkg::DIV_C_W'(36);
			end
			dcws_pkg::ST_P_MUL1: begin
				mul_a = dcws_pkg::MUL_A_W'(s2_q);
				mul_b = dcws_pkg::MUL_B_W'(pitch_lo_q);
			end
			dcws_pkg::ST_P_MUL2: begin
				mul_a = dcws_pkg::MUL_A_W'(d2_q);
				mul_b = dcws_pkg::MUL_B_W'(fdiff_mag);
			end
			dcws_pkg::ST_P_LIM: begin
				mul_a = dcws_pkg::MUL_A_W'(s2_q);
				mul_b = dcws_pkg::MUL_B_W'(pitch_hi_q);
			end
			dcws_pkg::ST_P_DEN: begin
				mul_a = dcws_pkg::MUL_A_W'(s2_q);
				mul_b = dcws_pkg::MUL_B_W'(rate_eff);
			end
			dcws_pkg::ST_P_DIV: begin
				// Clamped numerator times 65536, 47 bits, left aligned.
				div_num = {nclamp_q, 17'd0};
				div_den = den_q;
				div_n   = dcws_pkg::DIV_C_W'(47);
			end
			dcws_pkg::ST_T_MOD: begin
				// Integer part of the advanced phase reduced modulo the length.
				div_num = {sum_q[28:16], 35'd0};
				div_den = dcws_pkg::DIV_D_W'(len_eff);
				div_n   = dcws_pkg::DIV_C_W'(13);
			end
			dcws_pkg::ST_T_MUL: begin
				mul_a = dcws_pkg::MUL_A_W'(rd_mag);
				mul_b = dcws_pkg::MUL_B_W'(vol_q);
			end
			dcws_pkg::ST_T_DIV: begin
				div_num = {p_q[20:0], 27'd0};
				div_den = dcws_pkg::DIV_D_W'(max_vol_eff);
				div_n   = dcws_pkg::DIV_C_W'(21);
			end
			default: begin
			end
		endcase
	end

	// Sequencer: next state and unit launches.
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			dcws_pkg::ST_IDLE: begin
				if (item.valid) begin
					case (dcws_pkg::mode_t'(item.mode))
						dcws_pkg::MODE_TICK:  state_d = dcws_pkg::ST_T_MOD;
						dcws_pkg::MODE_VOL,
						dcws_pkg::MODE_PITCH: state_d = bad_status ? dcws_pkg::ST_DONE
						                                           : dcws_pkg::ST_SQ_D;
						default:              state_d = dcws_pkg::ST_DONE;
					endcase
				end
			end
			dcws_pkg::ST_SQ_D, dcws_pkg::ST_SQ_S, dcws_pkg::ST_VOL_MUL,
			dcws_pkg::ST_P_MUL1, dcws_pkg::ST_P_MUL2, dcws_pkg::ST_P_LIM,
			dcws_pkg::ST_P_DEN, dcws_pkg::ST_T_MUL: begin
				mul_start = !launch_q;
				if (mul_done) begin
					case (state_q)
						dcws_pkg::ST_SQ_D:    state_d = dcws_pkg::ST_SQ_S;
						dcws_pkg::ST_SQ_S:    state_d = (mode_q == dcws_pkg::MODE_VOL)
						                                ? dcws_pkg::ST_VOL_MUL
						                                : dcws_pkg::ST_P_MUL1;
						dcws_pkg::ST_VOL_MUL: state_d = dcws_pkg::ST_VOL_DIV;
						dcws_pkg::ST_P_MUL1:  state_d = dcws_pkg::ST_P_MUL2;
						dcws_pkg::ST_P_MUL2:  state_d = dcws_pkg::ST_P_LIM;
						dcws_pkg::ST_P_LIM:   state_d = dcws_pkg::ST_P_DEN;
						dcws_pkg::ST_P_DEN:   state_d = dcws_pkg::ST_P_DIV;
						default:              state_d = dcws_pkg::ST_T_DIV;
					endcase
				end
			end
			dcws_pkg::ST_VOL_DIV, dcws_pkg::ST_P_DIV, dcws_pkg::ST_T_DIV: begin
				div_start = !launch_q;
				if (div_done) begin
					state_d = dcws_pkg::ST_DONE;
				end
			end
			dcws_pkg::ST_T_MOD: begin
				div_start = !launch_q;
				if (div_done) begin
					state_d = dcws_pkg::ST_T_RD;
				end
			end
			dcws_pkg::ST_T_RD: begin
				// The table read of the new position lands in rd_q at this edge.
				state_d = dcws_pkg::ST_T_MUL;
			end
			dcws_pkg::ST_DONE: begin
				if (res_free) begin
					state_d = dcws_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dcws_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dcws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item.ready = (state_q == dcws_pkg::ST_IDLE);

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= dcws_pkg::MIN_DIST_RST;
			span_q     <= dcws_pkg::SPAN_RST;
			max_vol_q  <= dcws_pkg::MAX_VOL_RST;
			pitch_lo_q <= dcws_pkg::MIN_FREQ_RST;
			pitch_hi_q <= dcws_pkg::MAX_FREQ_RST;
			rate_q     <= dcws_pkg::RATE_RST;
			wave_len_q <= dcws_pkg::WAVE_LEN_RST;
		end else if (cfg_we) begin
			case (dcws_pkg::cfg_idx_t'(cfg_index))
				dcws_pkg::CFG_MIN_DIST: min_dist_q <= cfg_data[9:0];
				dcws_pkg::CFG_SPAN:     span_q     <= cfg_data[9:0];
				dcws_pkg::CFG_MAX_VOL:  max_vol_q  <= cfg_data[9:0];
				dcws_pkg::CFG_MIN_FREQ: pitch_lo_q <= cfg_data;
				dcws_pkg::CFG_MAX_FREQ: pitch_hi_q <= cfg_data;
				dcws_pkg::CFG_RATE:     rate_q     <= cfg_data[7:0];
				dcws_pkg::CFG_WAVE_LEN: wave_len_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Oscillator state and unit launch tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			step_q   <= dcws_pkg::STEP_RST;
			vol_q    <= dcws_pkg::VOLUME_RST;
			sample_q <= '0;
			launch_q <= 1'b0;
		end else begin
			if (mul_start || div_start) begin
				launch_q <= 1'b1;
			end else if (mul_done || div_done) begin
				launch_q <= 1'b0;
			end
			if (item_xfer && bad_status &&
			    (item.mode == dcws_pkg::MODE_VOL || item.mode == dcws_pkg::MODE_PITCH)) begin
				vol_q <= '0;
			end
			if (div_done) begin
				case (state_q)
					dcws_pkg::ST_VOL_DIV: begin
						vol_q <= (div_q > dcws_pkg::DIV_N_W'(max_vol_q)) ? max_vol_q
						                                                 : div_q[9:0];
					end
					dcws_pkg::ST_P_DIV: begin
						step_q <= (div_q > dcws_pkg::DIV_N_W'(dcws_pkg::STEP_MAX))
						          ? dcws_pkg::STEP_MAX : div_q[23:0];
					end
					dcws_pkg::ST_T_MOD: begin
						phase_q <= {div_r[IDX_W-1:0], sum_q[15:0]};
					end
					dcws_pkg::ST_T_DIV: begin
						if (samp_v < 0) begin
							sample_q <= '0;
						end else if (samp_v > 24'(dcws_pkg::DAC_MAX)) begin
							sample_q <= 12'(dcws_pkg::DAC_MAX);
						end else begin
							sample_q <= samp_v[11:0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Item capture and intermediate products.
	always_ff @(posedge clk) begin
		if (item_xfer) begin
			mode_q  <= dcws_pkg::mode_t'(item.mode);
			range_q <= item.range_mm;
			sum_q   <= 29'(phase_q) + 29'(step_q);
		end
		if (mul_done) begin
			case (state_q)
				dcws_pkg::ST_SQ_D:   d2_q <= mul_p[25:0];
				dcws_pkg::ST_SQ_S:   s2_q <= mul_p[19:0];
				dcws_pkg::ST_P_MUL1: t1_q <= mul_p[30:0];
				dcws_pkg::ST_P_MUL2: begin
					num_q <= fdiff[11] ? ($signed({8'b0, t1_q}) - $signed({2'b0, mul_p[36:0]}))
					                   : ($signed({8'b0, t1_q}) + $signed({2'b0, mul_p[36:0]}));
				end
				dcws_pkg::ST_P_LIM: begin
					// Above the ceiling the quotient equals the ceiling pitch times
					// 65536 over the rate.
					if (num_q > $signed({8'b0, mul_p[30:0]})) begin
						nclamp_q <= mul_p[30:0];
					end else if (num_q <= 0) begin
						nclamp_q <= '0;
					end else begin
						nclamp_q <= num_q[30:0];
					end
				end
				dcws_pkg::ST_P_DEN:  den_q <= mul_p[27:0];
				dcws_pkg::ST_VOL_MUL: p_q <= mul_p;
				dcws_pkg::ST_T_MUL: begin
					p_q   <= mul_p;
					neg_q <= rd_q[11];
				end
				default: begin
				end
			endcase
		end
	end

	// Waveform table.
	always_ff @(posedge clk) begin
		if (item_xfer && item.mode == dcws_pkg::MODE_WRITE &&
		    32'(item.table_index) < TABLE_DEPTH) begin
			wave_mem[IDX_W'(item.table_index)] <= item.table_value;
		end
		rd_q <= wave_mem[phase_q[PHASE_W-1:dcws_pkg::PHASE_FRAC_W]];
	end

	// Result register: loaded when the item finishes and the slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == dcws_pkg::ST_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dcws_pkg::ST_DONE && res_free) begin
			o_dac_q  <= sample_q;
			o_vol_q  <= vol_q;
			o_step_q <= step_q;
			o_pos_q  <= phase_ext[25:16];
		end
	end

	assign result.valid          = res_valid_q;
	assign result.dac_value      = o_dac_q;
	assign result.volume_level   = o_vol_q;
	assign result.phase_step     = o_step_q;
	assign result.table_position = o_pos_q;
endmodule

/* sv/dcws_mul.sv */
// Shift-add multiplier: one multiplier bit per cycle, LSB first.
module dcws_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dcws_pkg::MUL_A_W-1:0] a,
	input  logic [dcws_pkg::MUL_B_W-1:0] b,
	output logic                         done,
	output logic [dcws_pkg::MUL_P_W-1:0] prod
);
	localparam int CNT_W = $clog2(dcws_pkg::MUL_B_W + 1);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [dcws_pkg::MUL_P_W-1:0] a_q;
	logic [dcws_pkg::MUL_B_W-1:0] b_q;
	logic [dcws_pkg::MUL_P_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(dcws_pkg::MUL_B_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q   <= dcws_pkg::MUL_P_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

/* sv/dcws_div.sv */
// Restoring divider: one quotient bit per cycle. The dividend is left aligned and
// only its top n bits take part.
module dcws_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dcws_pkg::DIV_N_W-1:0] dividend,
	input  logic [dcws_pkg::DIV_D_W-1:0] divisor,
	input  logic [dcws_pkg::DIV_C_W-1:0] n,
	output logic                         done,
	output logic [dcws_pkg::DIV_N_W-1:0] quotient,
	output logic [dcws_pkg::DIV_D_W-1:0] remainder
);
	logic                         busy_q;
	logic                         done_q;
	logic [dcws_pkg::DIV_C_W-1:0] cnt_q;
	logic [dcws_pkg::DIV_N_W-1:0] num_q;
	logic [dcws_pkg::DIV_D_W-1:0] den_q;
	logic [dcws_pkg::DIV_D_W-1:0] rem_q;
	logic [dcws_pkg::DIV_N_W-1:0] quo_q;
	logic [dcws_pkg::DIV_D_W:0]   trial;
	logic                         fits;

	assign trial = {rem_q, num_q[dcws_pkg::DIV_N_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dcws_pkg::DIV_C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (fits) begin
				rem_q <= dcws_pkg::DIV_D_W'(trial - {1'b0, den_q});
			end else begin
				rem_q <= trial[dcws_pkg::DIV_D_W-1:0];
			end
			quo_q <= {quo_q[dcws_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule

/* sv/dcws_checker.sv */
module dcws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [11:0] dac_value,
	input logic [9:0]  volume_level,
	input logic [23:0] phase_step,
	input logic [9:0]  table_position
);
	// A stalled result keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(dac_value) &&
		$stable(volume_level) && $stable(phase_step) && $stable(table_position))
		else $error("result payload changed while stalled");

	// Only one item is in work: a transfer closes the item channel.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in work");

	// A new result only follows work on an item.
	a_res_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> !$past(item_ready))
		else $error("result appeared without an item in work");
endmodule

bind distance_controlled_wavetable_synth dcws_checker u_dcws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.dac_value      (result.dac_value),
	.volume_level   (result.volume_level),
	.phase_step     (result.phase_step),
	.table_position (result.table_position)
);
